### rtl/ggcg_pkg.sv
`timescale 1ns / 1ps
package ggcg_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // one face after classification in the front part
  typedef struct packed {
    logic [32:0] smag;   // |cell_value + other_value|
    logic        s_neg;
    logic [31:0] area;
    logic [31:0] nxm;
    logic        nx_neg;
    logic [31:0] nym;
    logic        ny_neg;
    logic [31:0] vol;
    logic        last;
  } face_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQX,
    BK_SQY,
    BK_ROOT,
    BK_DIVX,
    BK_DIVY,
    BK_MULP,
    BK_MULX,
    BK_MULY,
    BK_FINX,
    BK_FINY,
    BK_OUT
  } bk_state_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZVOL = 2'd2;

endpackage

### rtl/ggcg_front.sv
`timescale 1ns / 1ps
module ggcg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [191:0]          in_data_i,
  input  logic                  in_last_i,
  output logic                  push_o,
  input  logic                  push_ready_i,
  output ggcg_pkg::face_t       face_o
);

  logic            hold_q, hold_d;
  ggcg_pkg::face_t face_q, face_d;
  logic [32:0]     s;
  logic [31:0]     nx, ny;

  assign push_o     = hold_q && push_ready_i;
  assign in_ready_o = !hold_q || push_ready_i;
  assign face_o     = face_q;

  always_comb begin
    nx = in_data_i[127:96];
    ny = in_data_i[159:128];
    s  = {in_data_i[31], in_data_i[31:0]} + {in_data_i[63], in_data_i[63:32]};
    face_d        = face_q;
    face_d.smag   = s[32] ? (33'd0 - s) : s;
    face_d.s_neg  = s[32];
    face_d.area   = in_data_i[95:64];
    face_d.nxm    = nx[31] ? (32'd0 - nx) : nx;
    face_d.nx_neg = nx[31];
    face_d.nym    = ny[31] ? (32'd0 - ny) : ny;
    face_d.ny_neg = ny[31];
    face_d.vol    = in_data_i[191:160];
    face_d.last   = in_last_i;
    hold_d = hold_q;
    if (push_o) hold_d = 1'b0;
    if (in_valid_i && in_ready_o) hold_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      face_q <= face_d;
    end
  end

endmodule

### rtl/ggcg_fifo.sv
`timescale 1ns / 1ps
module ggcg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ggcg_pkg::face_t wdata_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_i,
  output ggcg_pkg::face_t rdata_o
);

  ggcg_pkg::face_t mem_q [2];
  logic            wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/ggcg_back.sv
`timescale 1ns / 1ps
module ggcg_back #(
  parameter int FRAC_BITS = ggcg_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            face_valid_i,
  input  ggcg_pkg::face_t face_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     grad_x_o,
  output logic [31:0]     grad_y_o,
  output logic [1:0]      status_o
);

  localparam int          SH    = 32 - FRAC_BITS;
  localparam logic [5:0]  STEPS = 6'd32;

  ggcg_pkg::bk_state_e state_q, state_d, after_face;
  logic [5:0]          cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic signed [63:0]  sum_x_q, sum_x_d, sum_y_q, sum_y_d;

  ggcg_pkg::face_t ent_q, ent_d;
  logic [63:0] acc_q, acc_d, mcand_q, mcand_d, pm_q, pm_d;
  logic [31:0] mplier_q, mplier_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [32:0] drem_q, drem_d;
  logic [31:0] dlow_q, dlow_d, quot_q, quot_d, den_q, den_d, ux_q, ux_d;
  logic [63:0] tx_q, tx_d;
  logic [31:0] gx_q, gx_d, gy_q, gy_d;
  logic        sat_q, sat_d, ovf_q, ovf_d;
  logic [31:0] ogx_q, ogx_d, ogy_q, ogy_d;
  logic [1:0]  ost_q, ost_d;

  logic [63:0] mul_n, fsum_mag, fsum_hi, ty;
  logic [35:0] rt_r, rt_t;
  logic        rt_ge, div_ge, last_step, fsum_neg;
  logic [32:0] div_t, fin_r;
  logic [31:0] root_n, quot_n;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [32:0] fin(input logic [31:0] q, input logic neg, input logic ovf);
    logic [31:0] lim, qq;
    logic        s;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    s   = ovf || (q > lim);
    qq  = s ? lim : q;
    return {s, neg ? (32'd0 - qq) : qq};
  endfunction

  assign pop_o       = (state_q == ggcg_pkg::BK_IDLE) && face_valid_i;
  assign out_valid_o = out_valid_q;
  assign grad_x_o    = ogx_q;
  assign grad_y_o    = ogy_q;
  assign status_o    = ost_q;

  always_comb begin
    // shared serial units, one bit per cycle
    mul_n  = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
    rt_r   = {rem_q, acc_q[63:62]};
    rt_t   = {2'b00, root_q, 2'b01};
    rt_ge  = (rt_r >= rt_t);
    root_n = {root_q[30:0], rt_ge};
    div_t  = {drem_q[31:0], dlow_q[31]};
    div_ge = (div_t >= {1'b0, den_q});
    quot_n = {quot_q[30:0], div_ge};

    fsum_neg = (state_q == ggcg_pkg::BK_FINY) ? sum_y_q[63] : sum_x_q[63];
    fsum_mag = (state_q == ggcg_pkg::BK_FINY) ?
               (sum_y_q[63] ? (64'd0 - sum_y_q) : sum_y_q) :
               (sum_x_q[63] ? (64'd0 - sum_x_q) : sum_x_q);
    fsum_hi  = fsum_mag >> SH;
    fin_r    = fin(quot_n, fsum_neg, ovf_q);
    ty       = (ent_q.s_neg ^ ent_q.ny_neg) ? (64'd0 - (mul_n >> FRAC_BITS))
                                            : (mul_n >> FRAC_BITS);

    if (!ent_q.last) after_face = ggcg_pkg::BK_IDLE;
    else if (ent_q.vol == 32'd0) after_face = ggcg_pkg::BK_OUT;
    else after_face = ggcg_pkg::BK_FINX;

    last_step = (cnt_q == STEPS);
    state_d = state_q;
    if (state_q == ggcg_pkg::BK_IDLE || state_q == ggcg_pkg::BK_OUT || last_step) begin
      cnt_d = 6'd0;
    end else begin
      cnt_d = cnt_q + 6'd1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    sum_x_d = sum_x_q;  sum_y_d = sum_y_q;
    ent_d = ent_q;      acc_d = acc_q;     mcand_d = mcand_q;  mplier_d = mplier_q;
    rem_d = rem_q;      root_d = root_q;   drem_d = drem_q;    dlow_d = dlow_q;
    quot_d = quot_q;    den_d = den_q;     ux_d = ux_q;        pm_d = pm_q;
    tx_d = tx_q;        gx_d = gx_q;       gy_d = gy_q;        sat_d = sat_q;
    ovf_d = ovf_q;      ogx_d = ogx_q;     ogy_d = ogy_q;      ost_d = ost_q;

    case (state_q)
      ggcg_pkg::BK_IDLE: begin
        if (face_valid_i) begin
          ent_d   = face_i;
          state_d = ggcg_pkg::BK_SQX;
        end
      end
      ggcg_pkg::BK_SQX, ggcg_pkg::BK_SQY, ggcg_pkg::BK_MULP,
      ggcg_pkg::BK_MULX, ggcg_pkg::BK_MULY: begin
        if (cnt_q == 6'd0) begin
          case (state_q)
            ggcg_pkg::BK_SQX: begin
              acc_d = 64'd0; mcand_d = {32'd0, ent_q.nxm}; mplier_d = ent_q.nxm;
            end
            ggcg_pkg::BK_SQY: begin
              mcand_d = {32'd0, ent_q.nym}; mplier_d = ent_q.nym;
            end
            ggcg_pkg::BK_MULP: begin
              acc_d = 64'd0; mcand_d = {31'd0, ent_q.smag}; mplier_d = ent_q.area;
            end
            ggcg_pkg::BK_MULX: begin
              acc_d = 64'd0; mcand_d = pm_q; mplier_d = ux_q;
            end
            default: begin
              acc_d = 64'd0; mcand_d = pm_q; mplier_d = quot_q;
            end
          endcase
        end else begin
          acc_d    = mul_n;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
          if (last_step) begin
            case (state_q)
              ggcg_pkg::BK_SQX: state_d = ggcg_pkg::BK_SQY;
              ggcg_pkg::BK_SQY: state_d = ggcg_pkg::BK_ROOT;
              ggcg_pkg::BK_MULP: begin
                pm_d    = mul_n >> (FRAC_BITS + 1);
                state_d = ggcg_pkg::BK_MULX;
              end
              ggcg_pkg::BK_MULX: begin
                tx_d    = (ent_q.s_neg ^ ent_q.nx_neg) ? (64'd0 - (mul_n >> FRAC_BITS))
                                                       : (mul_n >> FRAC_BITS);
                state_d = ggcg_pkg::BK_MULY;
              end
              default: begin
                sum_x_d = sat_add(sum_x_q, tx_q);
                sum_y_d = sat_add(sum_y_q, ty);
                state_d = after_face;
              end
            endcase
          end
        end
      end
      ggcg_pkg::BK_ROOT: begin
        // radicand sits in acc, two bits consumed per step
        if (cnt_q == 6'd0) begin
          rem_d  = 34'd0;
          root_d = 32'd0;
        end else begin
          acc_d  = acc_q << 2;
          rem_d  = rt_ge ? 34'(rt_r - rt_t) : rt_r[33:0];
          root_d = root_n;
          if (last_step) begin
            den_d   = root_n;
            state_d = (root_n == 32'd0) ? after_face : ggcg_pkg::BK_DIVX;
          end
        end
      end
      ggcg_pkg::BK_DIVX, ggcg_pkg::BK_DIVY, ggcg_pkg::BK_FINX, ggcg_pkg::BK_FINY: begin
        if (cnt_q == 6'd0) begin
          case (state_q)
            ggcg_pkg::BK_DIVX: begin
              drem_d = 33'(ent_q.nxm >> SH);
              dlow_d = 32'(ent_q.nxm << FRAC_BITS);
            end
            ggcg_pkg::BK_DIVY: begin
              drem_d = 33'(ent_q.nym >> SH);
              dlow_d = 32'(ent_q.nym << FRAC_BITS);
            end
            default: begin
              // quotient would not fit 32 bits when high part reaches the volume
              drem_d = fsum_hi[32:0];
              dlow_d = 32'(fsum_mag << FRAC_BITS);
              den_d  = ent_q.vol;
              ovf_d  = (fsum_hi >= {32'd0, ent_q.vol});
            end
          endcase
        end else begin
          drem_d = div_ge ? (div_t - {1'b0, den_q}) : div_t;
          dlow_d = dlow_q << 1;
          quot_d = quot_n;
          if (last_step) begin
            case (state_q)
              ggcg_pkg::BK_DIVX: begin
                ux_d    = quot_n;
                state_d = ggcg_pkg::BK_DIVY;
              end
              ggcg_pkg::BK_DIVY: state_d = ggcg_pkg::BK_MULP;
              ggcg_pkg::BK_FINX: begin
                gx_d    = fin_r[31:0];
                sat_d   = fin_r[32];
                state_d = ggcg_pkg::BK_FINY;
              end
              default: begin
                gy_d    = fin_r[31:0];
                sat_d   = sat_q | fin_r[32];
                state_d = ggcg_pkg::BK_OUT;
              end
            endcase
          end
        end
      end
      ggcg_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (ent_q.vol == 32'd0) begin
            ogx_d = 32'd0;
            ogy_d = 32'd0;
            ost_d = ggcg_pkg::STAT_ZVOL;
          end else begin
            ogx_d = gx_q;
            ogy_d = gy_q;
            ost_d = sat_q ? ggcg_pkg::STAT_SAT : ggcg_pkg::STAT_OK;
          end
          sum_x_d = 64'sd0;
          sum_y_d = 64'sd0;
          state_d = ggcg_pkg::BK_IDLE;
        end
      end
      default: state_d = ggcg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ggcg_pkg::BK_IDLE;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
      sum_x_q     <= 64'sd0;
      sum_y_q     <= 64'sd0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;   acc_q <= acc_d;     mcand_q <= mcand_d; mplier_q <= mplier_d;
    rem_q <= rem_d;   root_q <= root_d;   drem_q <= drem_d;   dlow_q <= dlow_d;
    quot_q <= quot_d; den_q <= den_d;     ux_q <= ux_d;       pm_q <= pm_d;
    tx_q <= tx_d;     gx_q <= gx_d;       gy_q <= gy_d;       sat_q <= sat_d;
    ovf_q <= ovf_d;   ogx_q <= ogx_d;     ogy_q <= ogy_d;     ost_q <= ost_d;
  end

endmodule

### rtl/green_gauss_cell_gradient.sv
`timescale 1ns / 1ps
// 2-D Green-Gauss cell gradient.
// Slave stream: one transfer per cell face; tlast marks the last face of a cell.
// Master stream: one transfer per cell, sent after its last face.
// A face runs through a serial back end that shares one shift-add multiplier,
// one restoring divider and one square-root unit, each retiring one bit per cycle.
// A zero-length normal skips the divides and multiplies; the last face adds the two
// volume divides, skipped for a zero volume, and the output load.
// A register stage and a two-entry queue sit in front, so up to three further
// faces are taken while the back end works.
// The result sits in an output register; the back end goes on only when a
// stalled result has been taken, and the front keeps taking faces until the
// queue and its register stage are full.
// Reset clears the running sums, the queue and the output valid.
module green_gauss_cell_gradient #(
  parameter int FRAC_BITS = ggcg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_value, other_value, face_area, normal_x, normal_y, cell_volume
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_face
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // grad_x, grad_y, status, zero pad
  output logic [71:0]  m_axis_tdata
);

  ggcg_pkg::face_t front_face, q_face;
  logic            push, push_ready, q_valid, pop;
  logic [31:0]     gx, gy;
  logic [1:0]      st;

  ggcg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .push_o       (push),
    .push_ready_i (push_ready),
    .face_o       (front_face)
  );

  ggcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_face),
    .ready_o (push_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (q_face)
  );

  ggcg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .face_valid_i (q_valid),
    .face_i       (q_face),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .grad_x_o     (gx),
    .grad_y_o     (gy),
    .status_o     (st)
  );

  assign m_axis_tdata = {6'd0, st, gy, gx};

endmodule

### verif/green_gauss_cell_gradient_test.sv
`timescale 1ns / 1ps
module green_gauss_cell_gradient_test;

  localparam int FB = ggcg_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  // lowest field last, to line up with the tdata packing
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grad_y;
    logic [31:0] grad_x;
  } grad_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // cell_value, other_value, face_area, normal_x, normal_y, cell_volume
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;  // last_face
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // grad_x, grad_y, status, zero pad
  logic [71:0]  m_axis_tdata;

  green_gauss_cell_gradient u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [63:0] acc_x, acc_y;
  grad_t grad_q[$];
  int errors = 0;
  int faces_sent = 0;
  int cells_seen = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] face_part(input logic [63:0] pm, input bit ps,
                                                   input logic signed [63:0] n,
                                                   input logic [63:0] len);
    logic [63:0] um, m;
    um = (mag(n) << FB) / len;
    m = (pm * um) >> FB;
    return (ps != n[63]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] scale_by_volume(input logic signed [63:0] s,
                                                  input logic [63:0] vol, inout bit sat);
    logic [63:0] m, qh, r, q, lim;
    m = mag(s);
    qh = m / vol;
    r = m % vol;
    lim = s[63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (qh > (64'hFFFF_FFFF >> FB)) begin
      q = lim;
      sat = 1'b1;
    end else begin
      q = (qh << FB) + ((r << FB) / vol);
      if (q > lim) begin
        q = lim;
        sat = 1'b1;
      end
    end
    if (s[63]) q = -q;
    return q[31:0];
  endfunction

  function automatic void predict_face(input logic [191:0] d, input bit last);
    logic signed [63:0] a, b, nx, ny, s;
    logic [63:0] area, vol, len, pm;
    grad_t g;
    bit sat;
    a = 64'($signed(d[31:0]));
    b = 64'($signed(d[63:32]));
    area = 64'(d[95:64]);
    nx = 64'($signed(d[127:96]));
    ny = 64'($signed(d[159:128]));
    vol = 64'(d[191:160]);
    len = root64(mag(nx) * mag(nx) + mag(ny) * mag(ny));
    if (len != 0) begin
      s = a + b;
      pm = (mag(s) * area) >> (FB + 1);
      acc_x = add_clamp(acc_x, face_part(pm, s[63], nx, len));
      acc_y = add_clamp(acc_y, face_part(pm, s[63], ny, len));
    end
    if (!last) return;
    if (vol == 0) begin
      g = '{grad_x: '0, grad_y: '0, status: ggcg_pkg::STAT_ZVOL};
    end else begin
      sat = 1'b0;
      g.grad_x = scale_by_volume(acc_x, vol, sat);
      g.grad_y = scale_by_volume(acc_y, vol, sat);
      g.status = sat ? ggcg_pkg::STAT_SAT : ggcg_pkg::STAT_OK;
    end
    grad_q.push_back(g);
    acc_x = 0;
    acc_y = 0;
  endfunction

  // tvalid stays high into the next transfer; it drops only while idling
  task automatic send_face(input logic [31:0] cv, ov, area, nx, ny, vol, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vol, ny, nx, area, ov, cv};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_face({vol, ny, nx, area, ov, cv}, last);
    faces_sent++;
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        grad_t got, want;
        got = m_axis_tdata[65:0];
        cells_seen++;
        if (grad_q.size() == 0) begin
          $display("%0t: unexpected gradient %h", $time, got);
          errors++;
        end else begin
          want = grad_q.pop_front();
          if (got.grad_x !== want.grad_x) begin
            $display("%0t: grad_x expected %h actual %h", $time, want.grad_x, got.grad_x);
            errors++;
          end
          if (got.grad_y !== want.grad_y) begin
            $display("%0t: grad_y expected %h actual %h", $time, want.grad_y, got.grad_y);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic rand_face(input bit last);
    logic [31:0] cv, ov, area, nx, ny, vol;
    cv = $urandom();
    ov = $urandom();
    area = $urandom();
    nx = $urandom();
    ny = $urandom();
    vol = $urandom();
    case ($urandom_range(7))
      0: begin
        cv = $signed(16'($urandom())) <<< 8;
        ov = $signed(16'($urandom())) <<< 8;
        area = $urandom_range(1 << 18);
        vol = $urandom_range(1 << 20, 1);
      end
      1: begin
        nx = 0;
        ny = 0;
      end
      2: vol = 0;
      3: vol = $urandom_range(255);
      4: begin
        nx = $urandom_range(3);
        ny = -$urandom_range(3);
      end
      default: ;
    endcase
    send_face(cv, ov, area, nx, ny, vol, last);
  endtask

  task automatic test_directed();
    // ordinary cell, unit normals around a square
    send_face(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    send_face(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
    send_face(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0);
    send_face(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 32'hFFFF_0000,
              32'h0001_0000, 1);
    // zero-length normal adds nothing
    send_face(32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 1);
    // zero volume
    send_face(32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
              32'h0004_0000, 0, 1);
    // extremes: saturate the gradient
    send_face(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0000_0001, 1);
    send_face(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'hFFFF_FFFF, 1);
    repeat (6) send_face(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_face(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
              32'hFFFF_FFFF, 32'h0000_0001, 1);
    send_face(0, 0, 0, 1, 1, 32'hFFFF_FFFF, 1);
    wait_drained();
  endtask

  task automatic test_random_cells(input int n_faces);
    int sent;
    sent = 0;
    while (sent < n_faces) begin
      int nf;
      nf = $urandom_range(6, 1);
      for (int i = 0; i < nf; i++) rand_face(i == nf - 1);
      sent += nf;
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls long in its own process; sender keeps offering faces
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 8; i++) rand_face(1'b1);
    join
    wait_drained();
  endtask

  initial begin
    acc_x = 0;
    acc_y = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 31;
    recv_idle_pct = 54;
    test_random_cells(700);
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 31;
    test_random_cells(700);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_cells(560);
    wait_drained();
    $display("Covered %0d faces and %0d cell gradients, incl. zero normals,", faces_sent,
             cells_seen);
    $display("zero volumes, saturation and long output stalls.");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/ggcg_pkg.sv
rtl/ggcg_front.sv
rtl/ggcg_fifo.sv
rtl/ggcg_back.sv
rtl/green_gauss_cell_gradient.sv
verif/green_gauss_cell_gradient_test.sv
